// File: sv/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: shared definitions for the bilinear image sampler
// Command codes, register indexes, fixed field widths and the store control
// bundle that passes between the sampler core and its image store.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Fixed field widths
  localparam int COORD_BITS    = 19;
  localparam int ADDR_BITS     = 16;
  localparam int STORE_DEPTH   = 1 << ADDR_BITS;
  localparam int PIX_PORT_BITS = 16;
  localparam int SIZE_BITS     = 9;
  localparam int REG_IDX_BITS  = 2;
  localparam int NUM_TAPS      = 4;

  // Parameter defaults
  localparam int PIXEL_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DEFAULT_VALUE = 2'd2;

  // Register reset values
  localparam logic [SIZE_BITS-1:0]     WIDTH_RST   = 9'd256;
  localparam logic [SIZE_BITS-1:0]     HEIGHT_RST  = 9'd256;
  localparam logic [PIX_PORT_BITS-1:0] DEFAULT_RST = 16'd0;

  // Neighbor order: top-left, top-right, bottom-left, bottom-right
  localparam int TAP_TL = 0;
  localparam int TAP_TR = 1;
  localparam int TAP_BL = 2;
  localparam int TAP_BR = 3;

  // Store control bundle
  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] wr_addr;
  } bis_mem_ctrl_t;

endpackage

// File: sv/bilinear_image_sampler_core.sv
// ----------------------------------------------------------------------------
// bilinear_image_sampler_core: pipelined bilinear sampler over a stored image
// Write transactions fill the image store; sample transactions return one
// interpolated pixel from the four neighbors around a fixed-point coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries write and sample
//   transactions; command_i selects which. A write stores pixel_value_i at
//   pixel_addr_i and produces no output. A sample returns one sample_value_o
//   on the output channel (out_valid_o / out_stall_i), in input order.
//   Configuration registers (width, height, default value) are written via
//   cfg_we_i / cfg_index_i / cfg_data_i while the block is idle.
//   Throughput: one transaction per cycle while out_stall_i is low; the
//   five-stage pipeline is set by the row-offset multiply, the neighbor
//   address adds with the registered four-copy store read, and the two
//   blend multiplies.
//   Reset: registers return to width 256, height 256, default 0; control
//   valid bits clear. Store contents are undefined until written; there is
//   no clearing pass.
//   Stall: while out_stall_i holds a result, upstream stages keep moving
//   until they fill, then in_stall_o rises. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bilinear_image_sampler_core
  import bis_pkg::*;
#(
  parameter int PixelBits = PIXEL_BITS_DEF,
  parameter int FracBits  = FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [REG_IDX_BITS-1:0]         cfg_index_i,
  input  logic [PIX_PORT_BITS-1:0]        cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [ADDR_BITS-1:0]            pixel_addr_i,
  input  logic [PIX_PORT_BITS-1:0]        pixel_value_i,
  input  logic signed [COORD_BITS-1:0]    coord_x_i,
  input  logic signed [COORD_BITS-1:0]    coord_y_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [PIX_PORT_BITS-1:0]        sample_value_o
);

  localparam int IntBits = COORD_BITS - FracBits;
  localparam int CmpBits = (IntBits + 1 > SIZE_BITS + 1) ? IntBits + 1 : SIZE_BITS + 1;
  localparam int HBits   = PixelBits + FracBits;
  localparam int HWide   = HBits + 2;
  localparam int VWide   = PixelBits + 2 * FracBits + 2;
  localparam logic signed [CmpBits-1:0] OneS = CmpBits'(1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SIZE_BITS-1:0]     width_q, height_q;
  logic [PIX_PORT_BITS-1:0] default_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      default_q <= DEFAULT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:   width_q   <= cfg_data_i[SIZE_BITS-1:0];
        REG_IMAGE_HEIGHT:  height_q  <= cfg_data_i[SIZE_BITS-1:0];
        REG_DEFAULT_VALUE: default_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when empty or when its successor moves
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_v_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic                         cmd1_q;
  logic [ADDR_BITS-1:0]         addr1_q;
  logic [PixelBits-1:0]         val1_q;
  logic signed [COORD_BITS-1:0] x1_q, y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q  <= command_i;
      addr1_q <= pixel_addr_i;
      val1_q  <= pixel_value_i[PixelBits-1:0];
      x1_q    <= coord_x_i;
      y1_q    <= coord_y_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 logic: floor/fraction split, bounds checks, row offset multiply
  // --------------------------------------------------------------------------
  logic signed [IntBits-1:0] cx, ry;
  logic signed [CmpBits-1:0] cx_e, cx1_e, ry_e, ry1_e, w_e, h_e;
  logic                      c0_ok, c1_ok, r0_ok, r1_ok;
  logic [NUM_TAPS-1:0]       ok1;
  logic [ADDR_BITS-1:0]      ry16, cx16, row_base;

  // arithmetic shift gives floor, low bits give x - floor(x)
  assign cx    = $signed(x1_q[COORD_BITS-1:FracBits]);
  assign ry    = $signed(y1_q[COORD_BITS-1:FracBits]);
  assign cx_e  = CmpBits'(cx);
  assign ry_e  = CmpBits'(ry);
  assign cx1_e = cx_e + OneS;
  assign ry1_e = ry_e + OneS;
  assign w_e   = $signed(CmpBits'(width_q));
  assign h_e   = $signed(CmpBits'(height_q));

  assign c0_ok = !cx_e[CmpBits-1]  && (cx_e  < w_e);
  assign c1_ok = !cx1_e[CmpBits-1] && (cx1_e < w_e);
  assign r0_ok = !ry_e[CmpBits-1]  && (ry_e  < h_e);
  assign r1_ok = !ry1_e[CmpBits-1] && (ry1_e < h_e);

  assign ok1[TAP_TL] = c0_ok && r0_ok;
  assign ok1[TAP_TR] = c1_ok && r0_ok;
  assign ok1[TAP_BL] = c0_ok && r1_ok;
  assign ok1[TAP_BR] = c1_ok && r1_ok;

  // store addresses wrap modulo the store depth
  assign ry16     = ADDR_BITS'(ry);
  assign cx16     = ADDR_BITS'(cx);
  assign row_base = ADDR_BITS'(ry16 * ADDR_BITS'(width_q));

  // --------------------------------------------------------------------------
  // Stage 2 register
  // --------------------------------------------------------------------------
  logic                 cmd2_q;
  logic [ADDR_BITS-1:0] addr2_q, base2_q, col2_q;
  logic [PixelBits-1:0] val2_q;
  logic [FracBits-1:0]  fx2_q, fy2_q;
  logic [NUM_TAPS-1:0]  ok2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cmd2_q  <= cmd1_q;
      addr2_q <= addr1_q;
      val2_q  <= val1_q;
      fx2_q   <= x1_q[FracBits-1:0];
      fy2_q   <= y1_q[FracBits-1:0];
      ok2_q   <= ok1;
      base2_q <= row_base;
      col2_q  <= cx16;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 logic: neighbor addresses and store access
  // --------------------------------------------------------------------------
  logic [NUM_TAPS-1:0][ADDR_BITS-1:0] rd_addr;
  logic [NUM_TAPS-1:0][PixelBits-1:0] rd_data;
  logic [ADDR_BITS-1:0]               a_tl, a_bl;
  bis_mem_ctrl_t                      mem_ctrl;

  assign a_tl = base2_q + col2_q;
  assign a_bl = a_tl + ADDR_BITS'(width_q);

  assign rd_addr[TAP_TL] = a_tl;
  assign rd_addr[TAP_TR] = a_tl + ADDR_BITS'(1);
  assign rd_addr[TAP_BL] = a_bl;
  assign rd_addr[TAP_BR] = a_bl + ADDR_BITS'(1);

  // a write transaction commits as it leaves stage 2
  assign mem_ctrl.wr_en   = en3 && v2_q && (cmd2_q == CMD_WRITE);
  assign mem_ctrl.rd_en   = en3;
  assign mem_ctrl.wr_addr = addr2_q;

  bis_store #(
    .PixelBits(PixelBits)
  ) u_store (
    .clk_i    (clk_i),
    .ctrl_i   (mem_ctrl),
    .wr_data_i(val2_q),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // --------------------------------------------------------------------------
  // Stage 3 register (read data lives in the store)
  // --------------------------------------------------------------------------
  logic [FracBits-1:0] fx3_q, fy3_q;
  logic [NUM_TAPS-1:0] ok3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q && (cmd2_q == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
      ok3_q <= ok2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 logic: default substitution and horizontal blend
  // --------------------------------------------------------------------------
  logic [NUM_TAPS-1:0][PixelBits-1:0] pix;
  logic signed [PixelBits:0]          d_top, d_bot;
  logic signed [FracBits:0]           fx_s;
  logic signed [HWide-1:0]            m_top, m_bot;

  for (genvar t = 0; t < NUM_TAPS; t++) begin : g_sel
    assign pix[t] = ok3_q[t] ? rd_data[t] : default_q[PixelBits-1:0];
  end

  assign fx_s  = $signed({1'b0, fx3_q});
  assign d_top = $signed({1'b0, pix[TAP_TR]}) - $signed({1'b0, pix[TAP_TL]});
  assign d_bot = $signed({1'b0, pix[TAP_BR]}) - $signed({1'b0, pix[TAP_BL]});
  assign m_top = $signed(HWide'({pix[TAP_TL], {FracBits{1'b0}}})) + HWide'(fx_s * d_top);
  assign m_bot = $signed(HWide'({pix[TAP_BL], {FracBits{1'b0}}})) + HWide'(fx_s * d_bot);

  // --------------------------------------------------------------------------
  // Stage 4 register
  // --------------------------------------------------------------------------
  logic [HBits-1:0]    m0_4_q, m1_4_q;
  logic [FracBits-1:0] fy4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      m0_4_q <= m_top[HBits-1:0];
      m1_4_q <= m_bot[HBits-1:0];
      fy4_q  <= fy3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4 logic: vertical blend, result is never negative
  // --------------------------------------------------------------------------
  logic signed [HBits:0]    d_v;
  logic signed [FracBits:0] fy_s;
  logic signed [VWide-1:0]  acc;

  assign fy_s = $signed({1'b0, fy4_q});
  assign d_v  = $signed({1'b0, m1_4_q}) - $signed({1'b0, m0_4_q});
  assign acc  = $signed(VWide'({m0_4_q, {FracBits{1'b0}}})) + VWide'(fy_s * d_v);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [PixelBits-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en5) begin
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      res_q <= acc[2*FracBits+PixelBits-1:2*FracBits];
    end
  end

  assign out_valid_o    = out_v_q;
  assign sample_value_o = PIX_PORT_BITS'(res_q);

endmodule

// File: sv/bis_store.sv
// ----------------------------------------------------------------------------
// bis_store: image store with four read ports
// Four identical copies of the image, each written at the same address and
// each read at one neighbor address, so all four taps arrive in the same cycle.
// Read data is registered and holds while rd_en is low.
// ----------------------------------------------------------------------------
module bis_store
  import bis_pkg::*;
#(
  parameter int PixelBits = PIXEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  bis_mem_ctrl_t                        ctrl_i,
  input  logic [PixelBits-1:0]                 wr_data_i,
  input  logic [NUM_TAPS-1:0][ADDR_BITS-1:0]   rd_addr_i,
  output logic [NUM_TAPS-1:0][PixelBits-1:0]   rd_data_o
);

  for (genvar t = 0; t < NUM_TAPS; t++) begin : g_copy
    logic [PixelBits-1:0] mem_q [STORE_DEPTH];
    logic [PixelBits-1:0] rd_q;

    // write port, shared address across copies
    always_ff @(posedge clk_i) begin
      if (ctrl_i.wr_en) begin
        mem_q[ctrl_i.wr_addr] <= wr_data_i;
      end
    end

    // registered read, held on stall
    always_ff @(posedge clk_i) begin
      if (ctrl_i.rd_en) begin
        rd_q <= mem_q[rd_addr_i[t]];
      end
    end

    assign rd_data_o[t] = rd_q;
  end

endmodule

// File: tb/sv/bis_sample_checker.sv
// ----------------------------------------------------------------------------
// bis_sample_checker: scoreboard for the bilinear image sampler
// Watches the configuration port and both channels, keeps a shadow copy of
// the image and the registers, predicts each interpolated pixel when its
// sample transaction is accepted and compares it with the returned one.
// ----------------------------------------------------------------------------
module bis_sample_checker
  import bis_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [REG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [PIX_PORT_BITS-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         command_i,
  input  logic [ADDR_BITS-1:0]         pixel_addr_i,
  input  logic [PIX_PORT_BITS-1:0]     pixel_value_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [PIX_PORT_BITS-1:0]     sample_value_i,
  output int                           mismatch_cnt_o,
  output int                           pending_o,
  output int                           checked_cnt_o
);

  localparam int FRAC = FRAC_BITS_DEF;

  // Shadow state
  logic [PIX_PORT_BITS-1:0] shadow_image [STORE_DEPTH];
  logic [SIZE_BITS-1:0]     shadow_width  = WIDTH_RST;
  logic [SIZE_BITS-1:0]     shadow_height = HEIGHT_RST;
  logic [PIX_PORT_BITS-1:0] shadow_default = DEFAULT_RST;

  // Predicted pixels, oldest first
  logic [PIX_PORT_BITS-1:0] expected_pixels [$];
  logic [PIX_PORT_BITS-1:0] want_pixel;
  int                       mismatches = 0;
  int                       checked    = 0;

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
    checked_cnt_o  = 0;
  end

  // One neighbor: default value outside the configured image
  function automatic longint neighbor_pixel(int col, int row);
    int lin;
    if (col < 0 || row < 0 || col >= int'(shadow_width) || row >= int'(shadow_height)) begin
      return longint'(shadow_default);
    end
    lin = row * int'(shadow_width) + col;
    return longint'(shadow_image[lin[ADDR_BITS-1:0]]);
  endfunction

  // Bilinear blend, horizontal first, truncated to one pixel
  function automatic logic [PIX_PORT_BITS-1:0] interp_pixel(
    logic signed [COORD_BITS-1:0] x,
    logic signed [COORD_BITS-1:0] y
  );
    int     col;
    int     row;
    longint one;
    longint fx;
    longint fy;
    longint p_tl;
    longint p_tr;
    longint p_bl;
    longint p_br;
    longint top_mix;
    longint bot_mix;
    longint acc;
    one  = longint'(1) << FRAC;
    col  = int'(x) >>> FRAC;   // floor, also for negative coordinates
    row  = int'(y) >>> FRAC;
    fx   = longint'(x[FRAC-1:0]);
    fy   = longint'(y[FRAC-1:0]);
    p_tl = neighbor_pixel(col, row);
    p_tr = neighbor_pixel(col + 1, row);
    p_bl = neighbor_pixel(col, row + 1);
    p_br = neighbor_pixel(col + 1, row + 1);
    top_mix = p_tl * one + fx * (p_tr - p_tl);
    bot_mix = p_bl * one + fx * (p_br - p_bl);
    acc     = top_mix * one + fy * (bot_mix - top_mix);
    if (acc < 0) begin
      acc = 0;
    end
    return acc[2*FRAC +: PIX_PORT_BITS];
  endfunction

  // Track config, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_width   = WIDTH_RST;
      shadow_height  = HEIGHT_RST;
      shadow_default = DEFAULT_RST;
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:   shadow_width   = cfg_data_i[SIZE_BITS-1:0];
          REG_IMAGE_HEIGHT:  shadow_height  = cfg_data_i[SIZE_BITS-1:0];
          REG_DEFAULT_VALUE: shadow_default = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == CMD_WRITE) begin
          shadow_image[pixel_addr_i] = pixel_value_i;
        end else begin
          expected_pixels.push_back(interp_pixel(coord_x_i, coord_y_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("sample_value: unexpected result 0x%04h, expected none", sample_value_i);
          mismatches++;
        end else begin
          want_pixel = expected_pixels.pop_front();
          checked++;
          if (sample_value_i !== want_pixel) begin
            $error("sample_value mismatch: expected 0x%04h, actual 0x%04h",
                   want_pixel, sample_value_i);
            mismatches++;
          end
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= expected_pixels.size();
    checked_cnt_o  <= checked;
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for bilinear_image_sampler_core
// Fills the image store and samples it under a series of register settings
// (reset values, single pixel, zero sizes, oversized stride with address
// wrap), with random gaps and stalls on both channels and one long output
// hold-off. A separate checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_top;
  import bis_pkg::*;

  localparam int ITEM_TARGET  = 1800;
  localparam int NUM_PHASES   = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;

  // DUT signals; the driven inputs are all known from time zero
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0]      cfg_index = REG_IMAGE_WIDTH;
  logic [PIX_PORT_BITS-1:0]     cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         command = CMD_WRITE;
  logic [ADDR_BITS-1:0]         pixel_addr = '0;
  logic [PIX_PORT_BITS-1:0]     pixel_value = '0;
  logic signed [COORD_BITS-1:0] coord_x = '0;
  logic signed [COORD_BITS-1:0] coord_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [PIX_PORT_BITS-1:0]     sample_value;

  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;

  // Stimulus bookkeeping
  bit                   written_map [STORE_DEPTH];
  logic [SIZE_BITS-1:0] cur_width  = WIDTH_RST;
  logic [SIZE_BITS-1:0] cur_height = HEIGHT_RST;
  int tx_cnt = 0;
  int sample_cnt = 0;
  int write_cnt = 0;
  int setting_cnt = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 84;
  bit pressure_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  bilinear_image_sampler_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .pixel_addr_i   (pixel_addr),
    .pixel_value_i  (pixel_value),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sample_value_o (sample_value)
  );

  bis_sample_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .pixel_addr_i   (pixel_addr),
    .pixel_value_i  (pixel_value),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .sample_value_i (sample_value),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt),
    .checked_cnt_o  (checked_cnt)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending_cnt);
    $display("Test completed with failures");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off once armed
  always @(posedge clk) begin
    if (pressure_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Pixel values with the extremes weighted in
  function automatic logic [PIX_PORT_BITS-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_PORT_BITS'($urandom);
    endcase
  endfunction

  // Fraction with the extremes weighted in
  function automatic int pick_frac();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // One input transaction; idling regime follows overall progress
  task automatic send_item(
    logic                         cmd,
    logic [ADDR_BITS-1:0]         addr,
    logic [PIX_PORT_BITS-1:0]     val,
    logic signed [COORD_BITS-1:0] x,
    logic signed [COORD_BITS-1:0] y
  );
    if (tx_cnt < ITEM_TARGET / 3) begin
      send_idle_pct = 12;
      recv_idle_pct = 84;
    end else if (tx_cnt < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 84;
      recv_idle_pct = 12;
    end else begin
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      pressure_armed = 1'b1;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    pixel_addr  <= addr;
    pixel_value <= val;
    coord_x     <= x;
    coord_y     <= y;
    do @(posedge clk); while (in_stall);
    tx_cnt++;
    if (cmd == CMD_WRITE) write_cnt++;
    else sample_cnt++;
  endtask

  task automatic write_pixel(logic [ADDR_BITS-1:0] addr, logic [PIX_PORT_BITS-1:0] val);
    send_item(CMD_WRITE, addr, val, COORD_BITS'($urandom), COORD_BITS'($urandom));
    written_map[addr] = 1'b1;
  endtask

  // Sample; first fill any in-image neighbor not yet written, sometimes
  // rewrite one right before the read
  task automatic sample_at(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y);
    int col;
    int row;
    int c;
    int r;
    int lin;
    col = int'(x) >>> FRAC_BITS_DEF;
    row = int'(y) >>> FRAC_BITS_DEF;
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        c = col + dc;
        r = row + dr;
        if (c >= 0 && r >= 0 && c < int'(cur_width) && r < int'(cur_height)) begin
          lin = r * int'(cur_width) + c;
          if (!written_map[lin[ADDR_BITS-1:0]] || $urandom_range(99) < 10) begin
            write_pixel(lin[ADDR_BITS-1:0], rand_pixel());
          end
        end
      end
    end
    send_item(CMD_SAMPLE, ADDR_BITS'($urandom), PIX_PORT_BITS'($urandom), x, y);
  endtask

  // Wait until every predicted pixel came back and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers only change while idle
  task automatic set_config(
    logic [SIZE_BITS-1:0]     w,
    logic [SIZE_BITS-1:0]     h,
    logic [PIX_PORT_BITS-1:0] dflt
  );
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= PIX_PORT_BITS'(w);
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= PIX_PORT_BITS'(h);
    @(posedge clk);
    cfg_index <= REG_DEFAULT_VALUE;
    cfg_data  <= dflt;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_width  = w;
    cur_height = h;
    setting_cnt++;
  endtask

  // Stimulus and verdict
  initial begin
    int                           phase_end;
    int                           col;
    int                           row;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners of the 256x256 reset image, fractions at both ends,
    // negative coordinates, partly and fully outside, coordinate extremes
    write_pixel(16'd0, 16'hFFFF);
    write_pixel(16'd1, 16'h0000);
    write_pixel(16'd256, 16'h0000);
    write_pixel(16'd257, 16'hFFFF);
    write_pixel(16'hFFFF, 16'hFFFF);
    write_pixel(16'hFFFE, 16'h0000);
    write_pixel(16'd65279, 16'h1234);
    write_pixel(16'd65278, 16'h8000);
    sample_at(19'sd0, 19'sd0);
    sample_at(19'sd128, 19'sd128);
    sample_at(19'sd255, 19'sd255);
    sample_at(-19'sd128, -19'sd128);
    sample_at(19'sd65152, 19'sd65152);
    sample_at(19'sd65408, 19'sd65408);
    sample_at(19'h40000, 19'h40000);
    sample_at(19'h3FFFF, 19'h3FFFF);
    sample_at(19'h3FFFF, 19'sd0);
    sample_at(19'sd0, 19'sd65535);
    wait_idle();

    // Random: mostly samples near the image, some far off, some stray writes
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       set_config(9'd256, 9'd256, rand_pixel());
        1:       set_config(9'd1, 9'd1, 16'hFFFF);
        2:       set_config(9'd511, 9'd511, rand_pixel());
        3:       set_config(9'd0, 9'd7, rand_pixel());
        4:       set_config(9'd9, 9'd0, rand_pixel());
        5:       set_config(9'd2, 9'd2, rand_pixel());
        7:       set_config(9'd256, 9'd1, 16'h0000);
        8:       set_config(9'd1, 9'd256, rand_pixel());
        default: set_config(SIZE_BITS'($urandom_range(256, 1)),
                            SIZE_BITS'($urandom_range(256, 1)), rand_pixel());
      endcase
      phase_end = ITEM_TARGET * (p + 1) / NUM_PHASES;
      while (tx_cnt < phase_end) begin
        if ($urandom_range(99) < 15) begin
          write_pixel(ADDR_BITS'($urandom), rand_pixel());
        end else if ($urandom_range(9) == 0) begin
          sample_at(COORD_BITS'($urandom), COORD_BITS'($urandom));
        end else begin
          col = int'($urandom_range(int'(cur_width) + 3)) - 2;
          row = int'($urandom_range(int'(cur_height) + 3)) - 2;
          sx  = COORD_BITS'(col * 256 + pick_frac());
          sy  = COORD_BITS'(row * 256 + pick_frac());
          sample_at(sx, sy);
        end
      end
      wait_idle();
    end

    $display("Covered %0d transactions (%0d samples, %0d pixel writes) over %0d settings",
             tx_cnt, sample_cnt, write_cnt, setting_cnt);
    $display("Compared %0d interpolated pixels, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
